[rtl/sensor_reply_frame_parser_core_defines.svh]
// Assertion macros shared by the parser RTL.
// Both expect clk and rst_n in scope.
`ifndef SENSOR_REPLY_FRAME_PARSER_CORE_DEFINES_SVH
`define SENSOR_REPLY_FRAME_PARSER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Property holds on every clock edge outside reset.
`define SRFP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("srfp assertion failed");

// When ante holds, cons holds in the next cycle.
`define SRFP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srfp assertion failed");

`else

`define SRFP_ASSERT(lbl, prop)
`define SRFP_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[rtl/srfp_pkg.sv]
`timescale 1ns / 1ps

package srfp_pkg;

    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 4;
    localparam int VALUE_W = 17;

    // frame phase codes
    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_COLLECT = 2'd1;
    localparam logic [1:0] PH_DONE    = 2'd2;

    // reply kind codes
    localparam logic [KIND_W-1:0] KIND_ZU   = 4'd0;
    localparam logic [KIND_W-1:0] KIND_ZL   = 4'd1;
    localparam logic [KIND_W-1:0] KIND_VU   = 4'd2;
    localparam logic [KIND_W-1:0] KIND_VL   = 4'd3;
    localparam logic [KIND_W-1:0] KIND_K    = 4'd4;
    localparam logic [KIND_W-1:0] KIND_M    = 4'd5;
    localparam logic [KIND_W-1:0] KIND_DOT  = 4'd6;
    localparam logic [KIND_W-1:0] KIND_SL   = 4'd7;
    localparam logic [KIND_W-1:0] KIND_SU   = 4'd8;
    localparam logic [KIND_W-1:0] KIND_G    = 4'd9;
    localparam logic [KIND_W-1:0] KIND_INFO = 4'd10;

    // characters
    localparam logic [BYTE_W-1:0] CH_NUL = 8'h00;
    localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SP  = 8'h20;
    localparam logic [BYTE_W-1:0] CH_0   = 8'h30;
    localparam logic [BYTE_W-1:0] CH_9   = 8'h39;

    typedef struct packed {
        logic              hit;
        logic [KIND_W-1:0] code;
    } hdr_t;

    // one result of a byte step
    typedef struct packed {
        logic               emit;
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
        logic               bad;
    } res_t;

    function automatic hdr_t header_code(input logic [BYTE_W-1:0] b);
        hdr_t h;
        h.hit  = 1'b1;
        h.code = KIND_ZU;
        unique case (b)
            8'h5A:   h.code = KIND_ZU;   // Z
            8'h7A:   h.code = KIND_ZL;   // z
            8'h56:   h.code = KIND_VU;   // V
            8'h76:   h.code = KIND_VL;   // v
            8'h4B:   h.code = KIND_K;    // K
            8'h4D:   h.code = KIND_M;    // M
            8'h2E:   h.code = KIND_DOT;  // .
            8'h73:   h.code = KIND_SL;   // s
            8'h53:   h.code = KIND_SU;   // S
            8'h47:   h.code = KIND_G;    // G
            8'h59:   h.code = KIND_INFO; // Y
            default: h.hit  = 1'b0;
        endcase
        return h;
    endfunction

    function automatic logic is_blank(input logic [BYTE_W-1:0] b);
        return (b == CH_SP) || (b == CH_NUL) || (b == CH_CR) || (b == CH_LF);
    endfunction

endpackage

[rtl/srfp_in_if.sv]
`timescale 1ns / 1ps

interface srfp_in_if;
    import srfp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

[rtl/srfp_out_if.sv]
`timescale 1ns / 1ps

interface srfp_out_if;
    import srfp_pkg::*;

    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  reply_kind;
    logic [VALUE_W-1:0] reply_value;
    logic               bad_header;

    modport source (output valid, output reply_kind, output reply_value,
                    output bad_header, input ready);
    modport sink (input valid, input reply_kind, input reply_value,
                  input bad_header, output ready);
endinterface

[rtl/sensor_reply_frame_parser_core.sv]
`timescale 1ns / 1ps
// Channel | Dir | Payload                                  | Beat
// rx      | in  | rx_byte[7:0]                             | one serial character
// reply   | out | reply_kind[3:0] reply_value[16:0] bad_hdr| one parsed frame or error
//
// One byte per cycle while rx is not stalled; a byte is consumed in the cycle it is accepted.
// A frame result comes out in the cycle after the byte that follows frame end is accepted.
// Reply is a registered stage; rx stalls only while a reply waits unread.
// Reset (async, rst_n low) returns the parser to idle with no reply pending.
module sensor_reply_frame_parser_core #(
    parameter int FRAME_BYTES   = 6,
    parameter int NUMBER_DIGITS = 5
) (
    input  logic       clk,
    input  logic       rst_n,
    srfp_in_if.sink    rx,
    srfp_out_if.source reply
);
    import srfp_pkg::*;

    res_t res;
    logic advance;

    assign rx.ready = !reply.valid || reply.ready;
    assign advance  = rx.valid && rx.ready;

    srfp_parse #(
        .FRAME_BYTES   (FRAME_BYTES),
        .NUMBER_DIGITS (NUMBER_DIGITS)
    ) u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .rx_byte (rx.rx_byte),
        .res     (res)
    );

    srfp_out u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (advance),
        .res   (res),
        .reply (reply)
    );

endmodule

[rtl/srfp_parse.sv]
`timescale 1ns / 1ps
`include "sensor_reply_frame_parser_core_defines.svh"

module srfp_parse #(
    parameter int FRAME_BYTES   = 6,
    parameter int NUMBER_DIGITS = 5
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  logic [srfp_pkg::BYTE_W-1:0] rx_byte,
    output srfp_pkg::res_t              res
);
    import srfp_pkg::*;

    localparam int BW = $clog2(FRAME_BYTES + 1);
    localparam int DW = $clog2(NUMBER_DIGITS + 1);

    logic [1:0]         phase_reg,  phase_next;
    logic [KIND_W-1:0]  kind_reg,   kind_next;
    logic [BW-1:0]      bytes_reg,  bytes_next;
    logic [VALUE_W-1:0] num_reg,    num_next;
    logic [DW-1:0]      digits_reg, digits_next;
    logic               closed_reg, closed_next;
    logic [1:0]         cr_reg,     cr_next;

    hdr_t               hdr;
    logic               is_digit;
    logic [BW-1:0]      bytes_inc;
    logic [DW-1:0]      digits_inc;
    logic [1:0]         cr_inc;
    logic [VALUE_W-1:0] num_x10;

    assign hdr        = header_code(rx_byte);
    assign is_digit   = (rx_byte >= CH_0) && (rx_byte <= CH_9);
    assign bytes_inc  = bytes_reg + 1'b1;
    assign digits_inc = digits_reg + 1'b1;
    assign cr_inc     = cr_reg + {1'b0, (rx_byte == CH_CR)};
    // value kept mod 2^17, which matches masking the full value at the end
    assign num_x10    = {num_reg[VALUE_W-4:0], 3'b000} + {num_reg[VALUE_W-2:0], 1'b0}
                      + {{(VALUE_W-4){1'b0}}, rx_byte[3:0]};

    always_comb
    begin
        phase_next  = phase_reg;
        kind_next   = kind_reg;
        bytes_next  = bytes_reg;
        num_next    = num_reg;
        digits_next = digits_reg;
        closed_next = closed_reg;
        cr_next     = cr_reg;
        res         = '0;

        unique case (phase_reg)
            PH_COLLECT:
            begin
                if (kind_reg == KIND_INFO)
                begin
                    cr_next = cr_inc;
                    if (cr_inc == 2'd2)
                        phase_next = PH_DONE;
                end
                else
                begin
                    bytes_next = bytes_inc;
                    if (!closed_reg && (rx_byte != CH_SP))
                    begin
                        if (is_digit)
                        begin
                            num_next    = num_x10;
                            digits_next = digits_inc;
                            if (digits_inc >= DW'(NUMBER_DIGITS))
                                closed_next = 1'b1;
                        end
                        else
                        begin
                            closed_next = 1'b1;
                        end
                    end
                    if ((rx_byte == CH_CR) || (rx_byte == CH_LF) || (rx_byte == CH_NUL)
                        || (bytes_inc >= BW'(FRAME_BYTES)))
                        phase_next = PH_DONE;
                end
            end
            PH_DONE:
            begin
                // this beat is swallowed; the finished frame goes out
                res.emit    = 1'b1;
                res.kind    = kind_reg;
                res.value   = (kind_reg == KIND_INFO) ? '0 : num_reg;
                phase_next  = PH_IDLE;
                kind_next   = KIND_ZU;
                bytes_next  = '0;
                num_next    = '0;
                digits_next = '0;
                closed_next = 1'b0;
            end
            default:
            begin
                phase_next = PH_IDLE;
                if (!is_blank(rx_byte))
                begin
                    if (hdr.hit)
                    begin
                        kind_next  = hdr.code;
                        phase_next = PH_COLLECT;
                        if (hdr.code == KIND_INFO)
                            cr_next = 2'd0;
                    end
                    else
                    begin
                        res.emit    = 1'b1;
                        res.bad     = 1'b1;
                        kind_next   = KIND_ZU;
                        bytes_next  = '0;
                        num_next    = '0;
                        digits_next = '0;
                        closed_next = 1'b0;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            kind_reg   <= KIND_ZU;
            bytes_reg  <= '0;
            num_reg    <= '0;
            digits_reg <= '0;
            closed_reg <= 1'b0;
            cr_reg     <= 2'd0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            kind_reg   <= kind_next;
            bytes_reg  <= bytes_next;
            num_reg    <= num_next;
            digits_reg <= digits_next;
            closed_reg <= closed_next;
            cr_reg     <= cr_next;
        end
    end

    `SRFP_ASSERT(a_bytes_bound, bytes_reg <= BW'(FRAME_BYTES))
    `SRFP_ASSERT(a_digits_bound, digits_reg <= DW'(NUMBER_DIGITS))
    `SRFP_ASSERT_NEXT(a_done_to_idle, advance && (phase_reg == PH_DONE), phase_reg == PH_IDLE)
    `SRFP_ASSERT(a_idle_clear, (phase_reg == PH_IDLE) |-> ((num_reg == '0) && !closed_reg))

endmodule

[rtl/srfp_out.sv]
`timescale 1ns / 1ps
`include "sensor_reply_frame_parser_core_defines.svh"

module srfp_out (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  srfp_pkg::res_t res,
    srfp_out_if.source     reply
);
    import srfp_pkg::*;

    logic               valid_reg, valid_next;
    logic [KIND_W-1:0]  kind_reg;
    logic [VALUE_W-1:0] value_reg;
    logic               bad_reg;
    logic               take;

    assign take = load && res.emit;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
            valid_next = 1'b1;
        else if (reply.ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            kind_reg  <= res.kind;
            value_reg <= res.value;
            bad_reg   <= res.bad;
        end
    end

    assign reply.valid       = valid_reg;
    assign reply.reply_kind  = kind_reg;
    assign reply.reply_value = value_reg;
    assign reply.bad_header  = bad_reg;

    `SRFP_ASSERT(a_no_overwrite, (valid_reg && !reply.ready) |-> !take)
    `SRFP_ASSERT_NEXT(a_take_shows, take, valid_reg)

endmodule
